/* rtl/core/tilt_proportional_drive_steer_assert.svh */
// Assertion macros shared by the tilt steering block.
`ifndef TILT_PROPORTIONAL_DRIVE_STEER_ASSERT_SVH
`define TILT_PROPORTIONAL_DRIVE_STEER_ASSERT_SVH

// The condition and its consequence hold in the same cycle.
`define TPDS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence holds in the cycle after the condition.
`define TPDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tpds_pkg.sv */
// Types and constants shared by the tilt steering block.
package tpds_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int TILT_W     = 13;
    localparam int WIDTH_W    = 16;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [WIDTH_W-1:0] CENTER_W  = 16'd2765;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX = 16'hFFFF;

    typedef enum logic [0:0] {
        OP_CAL = 1'b0,
        OP_RUN = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        DIR_UPHILL   = 2'd0,
        DIR_DOWNHILL = 2'd1,
        DIR_NONE     = 2'd2
    } dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIRECTION    = 3'd0,
        REG_STEER_GAIN   = 3'd1,
        REG_DRIVE_X_GAIN = 3'd2,
        REG_DRIVE_Y_GAIN = 3'd3,
        REG_STOP_BAND_X  = 3'd4,
        REG_STOP_BAND_Y  = 3'd5
    } cfg_reg_t;

    localparam dir_t       DIRECTION_RST    = DIR_UPHILL;
    localparam logic [7:0] STEER_GAIN_RST   = 8'd5;
    localparam logic [7:0] DRIVE_X_GAIN_RST = 8'd6;
    localparam logic [5:0] DRIVE_Y_GAIN_RST = 6'd3;
    localparam logic [7:0] STOP_BAND_X_RST  = 8'd10;
    localparam logic [7:0] STOP_BAND_Y_RST  = 8'd20;

endpackage

/* rtl/core/tpds_if.sv */
// Handshake interfaces for the sample, result and configuration channels.
interface tpds_sample_if;
    logic                           valid;
    logic                           ready;
    tpds_pkg::opcode_t              opcode;
    logic [tpds_pkg::BYTE_W-1:0]    accel_x_byte;
    logic [tpds_pkg::BYTE_W-1:0]    accel_y_byte;

    modport source (output valid, opcode, accel_x_byte, accel_y_byte, input ready);
    modport sink   (input valid, opcode, accel_x_byte, accel_y_byte, output ready);
endinterface

interface tpds_result_if;
    logic                                valid;
    logic                                ready;
    logic [tpds_pkg::WIDTH_W-1:0]        steering_width;
    logic [tpds_pkg::WIDTH_W-1:0]        drive_width;
    logic                                stopped;
    logic signed [tpds_pkg::TILT_W-1:0]  tilt_x;
    logic signed [tpds_pkg::TILT_W-1:0]  tilt_y;

    modport source (output valid, steering_width, drive_width, stopped, tilt_x, tilt_y,
                    input ready);
    modport sink   (input valid, steering_width, drive_width, stopped, tilt_x, tilt_y,
                    output ready);
endinterface

interface tpds_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tpds_pkg::CFG_IDX_W-1:0]    index;
    logic [tpds_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/tilt_proportional_drive_steer.sv */
// Top level of the tilt proportional drive and steering controller.
//
// Items arrive on the samples channel: a calibration or run opcode and the two
// accelerometer high bytes. Every CAL_SAMPLES calibration items replace the zero
// offset; every AVG_SAMPLES run items form one group and give one item on the
// results channel, carrying the steering and drive widths, the stop flag and the
// two tilts. Items that close no group give no result.
// The cfg channel writes the six control registers and is always ready; the user
// must see it is written only while the block is idle; the block does not enforce it.
// A run item that closes a group gives its result through five register stages:
// sums, reciprocal multiply, tilt, gain multiply, output. One item is accepted per
// cycle while the stages can move; after the last item of a calibration block the
// samples channel is held off while the offset is divided out and written.
// When the receiver stalls, the output register holds its item and the stages
// behind it fill, so items are still taken until every stage is occupied.
// Reset clears all sums, counters, the offset and the stop latch, centres the
// held steering width and loads the default register values.
module tilt_proportional_drive_steer #(
    parameter int CAL_SAMPLES = 64,
    parameter int AVG_SAMPLES = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    tpds_sample_if.sink   samples,
    tpds_result_if.source results,
    tpds_cfg_if.sink      cfg
);

`include "tilt_proportional_drive_steer_assert.svh"

    localparam int SW     = tpds_pkg::SAMPLE_W;
    localparam int TW     = tpds_pkg::TILT_W;
    localparam int WW     = tpds_pkg::WIDTH_W;
    localparam int CAL_SW = 13 + $clog2(CAL_SAMPLES);
    localparam int RUN_SW = 13 + $clog2(AVG_SAMPLES);
    localparam int CAL_CW = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
    localparam int RUN_CW = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
    localparam logic [CAL_CW-1:0] CAL_LAST = CAL_CW'(CAL_SAMPLES - 1);
    localparam logic [RUN_CW-1:0] RUN_LAST = RUN_CW'(AVG_SAMPLES - 1);

    function automatic logic [WW-1:0] sat16(input logic signed [22:0] v);
        logic [WW-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > 23'sd65535)
        begin
            r = tpds_pkg::WIDTH_MAX;
        end
        else
        begin
            r = v[WW-1:0];
        end
        return r;
    endfunction

    // Control registers.
    tpds_pkg::dir_t direction_reg;
    logic [7:0]     steer_gain_reg;
    logic [7:0]     drive_x_gain_reg;
    logic [5:0]     drive_y_gain_reg;
    logic [7:0]     stop_band_x_reg;
    logic [7:0]     stop_band_y_reg;

    // Accumulators and calibration state.
    logic signed [CAL_SW-1:0] cal_sum_x_reg, cal_sum_y_reg;
    logic signed [CAL_SW-1:0] cal_sum_x_next, cal_sum_y_next;
    logic signed [CAL_SW-1:0] cal_fin_x_reg, cal_fin_y_reg;
    logic [CAL_CW-1:0]        cal_count_reg;
    logic                     cal_pend1_reg, cal_pend2_reg;
    logic signed [SW-1:0]     offset_x_reg, offset_y_reg;
    logic signed [SW-1:0]     cal_q_x, cal_q_y;
    logic signed [RUN_SW-1:0] run_sum_x_reg, run_sum_y_reg;
    logic signed [RUN_SW-1:0] run_sum_x_next, run_sum_y_next;
    logic [RUN_CW-1:0]        run_count_reg;
    logic                     stop_latch_reg;
    logic [WW-1:0]            held_steering_reg;

    // Handshake and stage control.
    logic                 in_fire, is_cal, cal_done, run_done;
    logic                 en0, en1, en2, en3, en4;
    logic                 v0_reg, v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic signed [SW-1:0] samp_x, samp_y;

    // Stage payloads.
    logic signed [RUN_SW-1:0] grp_x_reg, grp_y_reg;
    logic signed [SW-1:0]     off_x0_reg, off_y0_reg, off_x1_reg, off_y1_reg;
    logic signed [SW-1:0]     run_q_x, run_q_y;
    logic signed [TW-1:0]     tilt_x2_reg, tilt_y2_reg, tilt_x3_reg, tilt_y3_reg;
    logic [SW-1:0]            abs_x, abs_y;
    logic signed [21:0]       steer_prod3_reg;
    logic [19:0]              drive_px3_reg;
    logic [17:0]              drive_py3_reg;
    logic                     level3_reg;

    // Final stage.
    logic signed [22:0] steer_up, steer_down;
    logic [21:0]        drive_sum;
    logic [WW-1:0]      held_next;
    logic               stop_next;
    logic [WW-1:0]      steer_out_next, drive_out_next;
    logic [WW-1:0]      steer_out_reg, drive_out_reg;
    logic               stopped_out_reg;
    logic signed [TW-1:0] tilt_x_out_reg, tilt_y_out_reg;

    assign en4 = !out_valid_reg || results.ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;

    assign samples.ready = en0 && !cal_pend1_reg && !cal_pend2_reg;
    assign cfg.ready     = 1'b1;

    assign in_fire  = samples.valid && samples.ready;
    assign is_cal   = (samples.opcode == tpds_pkg::OP_CAL);
    assign samp_x   = signed'({samples.accel_x_byte, 4'b0000});
    assign samp_y   = signed'({samples.accel_y_byte, 4'b0000});
    assign cal_done = in_fire && is_cal && (cal_count_reg == CAL_LAST);
    assign run_done = in_fire && !is_cal && (run_count_reg == RUN_LAST);

    assign cal_sum_x_next = cal_sum_x_reg + CAL_SW'(samp_x);
    assign cal_sum_y_next = cal_sum_y_reg + CAL_SW'(samp_y);
    assign run_sum_x_next = run_sum_x_reg + RUN_SW'(samp_x);
    assign run_sum_y_next = run_sum_y_reg + RUN_SW'(samp_y);

    tpds_cdiv #(.DIVISOR(CAL_SAMPLES), .IN_W(CAL_SW), .FLOOR(1'b0)) u_cal_div_x (
        .clk      (clk),
        .load     (cal_pend1_reg),
        .dividend (cal_fin_x_reg),
        .quotient (cal_q_x)
    );

    tpds_cdiv #(.DIVISOR(CAL_SAMPLES), .IN_W(CAL_SW), .FLOOR(1'b0)) u_cal_div_y (
        .clk      (clk),
        .load     (cal_pend1_reg),
        .dividend (cal_fin_y_reg),
        .quotient (cal_q_y)
    );

    tpds_cdiv #(.DIVISOR(AVG_SAMPLES), .IN_W(RUN_SW), .FLOOR(1'b1)) u_run_div_x (
        .clk      (clk),
        .load     (en1),
        .dividend (grp_x_reg),
        .quotient (run_q_x)
    );

    tpds_cdiv #(.DIVISOR(AVG_SAMPLES), .IN_W(RUN_SW), .FLOOR(1'b1)) u_run_div_y (
        .clk      (clk),
        .load     (en1),
        .dividend (grp_y_reg),
        .quotient (run_q_y)
    );

    // Control registers and accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg    <= tpds_pkg::DIRECTION_RST;
            steer_gain_reg   <= tpds_pkg::STEER_GAIN_RST;
            drive_x_gain_reg <= tpds_pkg::DRIVE_X_GAIN_RST;
            drive_y_gain_reg <= tpds_pkg::DRIVE_Y_GAIN_RST;
            stop_band_x_reg  <= tpds_pkg::STOP_BAND_X_RST;
            stop_band_y_reg  <= tpds_pkg::STOP_BAND_Y_RST;
            cal_sum_x_reg    <= '0;
            cal_sum_y_reg    <= '0;
            cal_count_reg    <= '0;
            cal_pend1_reg    <= 1'b0;
            cal_pend2_reg    <= 1'b0;
            offset_x_reg     <= '0;
            offset_y_reg     <= '0;
            run_sum_x_reg    <= '0;
            run_sum_y_reg    <= '0;
            run_count_reg    <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (tpds_pkg::cfg_reg_t'(cfg.index))
                    tpds_pkg::REG_DIRECTION:    direction_reg <= tpds_pkg::dir_t'(cfg.data[1:0]);
                    tpds_pkg::REG_STEER_GAIN:   steer_gain_reg   <= cfg.data;
                    tpds_pkg::REG_DRIVE_X_GAIN: drive_x_gain_reg <= cfg.data;
                    tpds_pkg::REG_DRIVE_Y_GAIN: drive_y_gain_reg <= cfg.data[5:0];
                    tpds_pkg::REG_STOP_BAND_X:  stop_band_x_reg  <= cfg.data;
                    tpds_pkg::REG_STOP_BAND_Y:  stop_band_y_reg  <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end

            cal_pend1_reg <= cal_done;
            cal_pend2_reg <= cal_pend1_reg;
            if (cal_pend2_reg)
            begin
                offset_x_reg <= cal_q_x;
                offset_y_reg <= cal_q_y;
            end

            if (in_fire && is_cal)
            begin
                if (cal_done)
                begin
                    cal_sum_x_reg <= '0;
                    cal_sum_y_reg <= '0;
                    cal_count_reg <= '0;
                end
                else
                begin
                    cal_sum_x_reg <= cal_sum_x_next;
                    cal_sum_y_reg <= cal_sum_y_next;
                    cal_count_reg <= cal_count_reg + 1'b1;
                end
            end

            if (in_fire && !is_cal)
            begin
                if (run_done)
                begin
                    run_sum_x_reg <= '0;
                    run_sum_y_reg <= '0;
                    run_count_reg <= '0;
                end
                else
                begin
                    run_sum_x_reg <= run_sum_x_next;
                    run_sum_y_reg <= run_sum_y_next;
                    run_count_reg <= run_count_reg + 1'b1;
                end
            end
        end
    end

    // Stage valid bits and the state that results update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg            <= 1'b0;
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            v3_reg            <= 1'b0;
            out_valid_reg     <= 1'b0;
            stop_latch_reg    <= 1'b0;
            held_steering_reg <= tpds_pkg::CENTER_W;
        end
        else
        begin
            if (en0)
            begin
                v0_reg <= run_done;
            end
            if (en1)
            begin
                v1_reg <= v0_reg;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                out_valid_reg <= v3_reg;
                if (v3_reg)
                begin
                    stop_latch_reg    <= stop_next;
                    held_steering_reg <= held_next;
                end
            end
        end
    end

    always_comb
    begin
        abs_x = tilt_x2_reg[TW-1] ? SW'(-tilt_x2_reg) : SW'(tilt_x2_reg);
        abs_y = tilt_y2_reg[TW-1] ? SW'(-tilt_y2_reg) : SW'(tilt_y2_reg);
    end

    always_comb
    begin
        steer_up   = $signed({7'b0000000, tpds_pkg::CENTER_W}) + 23'(steer_prod3_reg);
        steer_down = $signed({7'b0000000, tpds_pkg::CENTER_W}) - 23'(steer_prod3_reg);
        drive_sum  = 22'(tpds_pkg::CENTER_W) + 22'(drive_px3_reg) + 22'(drive_py3_reg);
        held_next  = held_steering_reg;
        if (!stop_latch_reg)
        begin
            unique case (direction_reg)
                tpds_pkg::DIR_UPHILL:   held_next = sat16(steer_up);
                tpds_pkg::DIR_DOWNHILL: held_next = sat16(steer_down);
                default:                held_next = held_steering_reg;
            endcase
        end
        stop_next = stop_latch_reg || level3_reg;
        if (stop_next)
        begin
            steer_out_next = tpds_pkg::CENTER_W;
            drive_out_next = tpds_pkg::CENTER_W;
        end
        else
        begin
            steer_out_next = held_next;
            drive_out_next = sat16(signed'({1'b0, drive_sum}));
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (cal_done)
        begin
            cal_fin_x_reg <= cal_sum_x_next;
            cal_fin_y_reg <= cal_sum_y_next;
        end
        if (run_done)
        begin
            grp_x_reg  <= run_sum_x_next;
            grp_y_reg  <= run_sum_y_next;
            off_x0_reg <= offset_x_reg;
            off_y0_reg <= offset_y_reg;
        end
        if (en1)
        begin
            off_x1_reg <= off_x0_reg;
            off_y1_reg <= off_y0_reg;
        end
        if (en2)
        begin
            tilt_x2_reg <= TW'(run_q_x) - TW'(off_x1_reg);
            tilt_y2_reg <= TW'(run_q_y) - TW'(off_y1_reg);
        end
        if (en3)
        begin
            tilt_x3_reg     <= tilt_x2_reg;
            tilt_y3_reg     <= tilt_y2_reg;
            steer_prod3_reg <= 22'($signed({1'b0, steer_gain_reg})) * 22'(tilt_x2_reg);
            drive_px3_reg   <= 20'(drive_x_gain_reg) * 20'(abs_x);
            drive_py3_reg   <= 18'(drive_y_gain_reg) * 18'(abs_y);
            level3_reg      <= (abs_x < SW'(stop_band_x_reg)) && (abs_y < SW'(stop_band_y_reg));
        end
        if (en4 && v3_reg)
        begin
            steer_out_reg   <= steer_out_next;
            drive_out_reg   <= drive_out_next;
            stopped_out_reg <= stop_next;
            tilt_x_out_reg  <= tilt_x3_reg;
            tilt_y_out_reg  <= tilt_y3_reg;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.steering_width = steer_out_reg;
    assign results.drive_width    = drive_out_reg;
    assign results.stopped        = stopped_out_reg;
    assign results.tilt_x         = tilt_x_out_reg;
    assign results.tilt_y         = tilt_y_out_reg;

    `TPDS_ASSERT_NEXT(a_stop_sticks, stop_latch_reg, stop_latch_reg,
        "Stop latch cleared without a reset.")
    `TPDS_ASSERT_SAME(a_stopped_centred, results.valid && results.stopped,
        results.steering_width == tpds_pkg::CENTER_W && results.drive_width == tpds_pkg::CENTER_W,
        "Stopped result is not centred.")
    `TPDS_ASSERT_SAME(a_drive_floor, results.valid, results.drive_width >= tpds_pkg::CENTER_W,
        "Drive width below centre.")
    `TPDS_ASSERT_NEXT(a_cal_hold, cal_pend1_reg, cal_pend2_reg && !samples.ready,
        "Samples taken while the offset is being divided out.")

endmodule

/* rtl/core/tpds_cdiv.sv */
// Signed division by a constant through a registered reciprocal multiplication.
module tpds_cdiv #(
    parameter int DIVISOR = 64,
    parameter int IN_W    = 19,
    parameter bit FLOOR   = 1'b0
) (
    input  logic                                  clk,
    input  logic                                  load,
    input  logic signed [IN_W-1:0]                dividend,
    output logic signed [tpds_pkg::SAMPLE_W-1:0]  quotient
);

    localparam int DIV_W = $clog2(DIVISOR);
    localparam int AW    = IN_W;
    localparam int K     = AW + DIV_W;
    localparam int MW    = AW + 2;
    localparam int PW    = AW + MW;
    localparam logic [63:0] MULT =
        ((64'd1 << K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [AW-1:0] NEG_ADD = FLOOR ? AW'(DIVISOR) : AW'(1);

    logic [AW-1:0]                  mag;
    logic                           neg;
    logic [PW-1:0]                  prod_reg;
    logic                           neg_reg;
    logic [tpds_pkg::SAMPLE_W-1:0]  q_mag;

    // For FLOOR, rounding down biases a negative magnitude by the divisor less one.
    always_comb
    begin
        neg = dividend[IN_W-1];
        if (neg)
        begin
            mag = ~unsigned'(dividend) + NEG_ADD;
        end
        else
        begin
            mag = unsigned'(dividend);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            neg_reg  <= neg;
            prod_reg <= PW'(mag) * PW'(MULT[MW-1:0]);
        end
    end

    always_comb
    begin
        q_mag = prod_reg[K +: tpds_pkg::SAMPLE_W];
        if (neg_reg)
        begin
            quotient = signed'(~q_mag + 1'b1);
        end
        else
        begin
            quotient = signed'(q_mag);
        end
    end

endmodule

/* test/tpds_drive_checker.sv */
`timescale 1ns / 100ps
// Checker that predicts every result item of the tilt steering block and compares it.
module tpds_drive_checker
    import tpds_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    tpds_sample_if samples,
    tpds_result_if results,
    tpds_cfg_if    cfg,
    output int     fail_count,
    output int     pending,
    output int     groups_checked,
    output int     stop_groups,
    output int     cal_blocks
);

    localparam int CAL_SAMPLES = 64;
    localparam int AVG_SAMPLES = 8;

    typedef struct {
        logic [WIDTH_W-1:0]       steering_width;
        logic [WIDTH_W-1:0]       drive_width;
        logic                     stopped;
        logic signed [TILT_W-1:0] tilt_x;
        logic signed [TILT_W-1:0] tilt_y;
    } steer_result_t;

    steer_result_t awaited_groups[$];

    logic [1:0]         direction;
    logic [7:0]         steer_gain;
    logic [7:0]         drive_x_gain;
    logic [5:0]         drive_y_gain;
    logic [7:0]         stop_band_x;
    logic [7:0]         stop_band_y;
    int                 cal_sum_x;
    int                 cal_sum_y;
    int                 cal_count;
    int                 offset_x;
    int                 offset_y;
    int                 run_sum_x;
    int                 run_sum_y;
    int                 run_count;
    logic               stop_latch;
    logic [WIDTH_W-1:0] held_steering;
    int                 mismatches;
    int                 n_groups;
    int                 n_stops;
    int                 n_cal;

    function automatic int accel_value(logic [BYTE_W-1:0] b);
        return int'($signed(b)) * 16;
    endfunction

    function automatic int floor_avg(int s);
        int q;
        q = s / AVG_SAMPLES;
        if (s < 0 && q * AVG_SAMPLES != s)
            q = q - 1;
        return q;
    endfunction

    function automatic logic [WIDTH_W-1:0] clamp_width(longint v);
        if (v < 0)
            return '0;
        if (v > longint'(WIDTH_MAX))
            return WIDTH_MAX;
        return WIDTH_W'(v);
    endfunction

    task automatic clear_state();
        direction     = DIRECTION_RST;
        steer_gain    = STEER_GAIN_RST;
        drive_x_gain  = DRIVE_X_GAIN_RST;
        drive_y_gain  = DRIVE_Y_GAIN_RST;
        stop_band_x   = STOP_BAND_X_RST;
        stop_band_y   = STOP_BAND_Y_RST;
        cal_sum_x     = 0;
        cal_sum_y     = 0;
        cal_count     = 0;
        offset_x      = 0;
        offset_y      = 0;
        run_sum_x     = 0;
        run_sum_y     = 0;
        run_count     = 0;
        stop_latch    = 1'b0;
        held_steering = CENTER_W;
        mismatches    = 0;
        n_groups      = 0;
        n_stops       = 0;
        n_cal         = 0;
        awaited_groups.delete();
    endtask

    task automatic apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_DIRECTION:    direction    = value[1:0];
            REG_STEER_GAIN:   steer_gain   = value;
            REG_DRIVE_X_GAIN: drive_x_gain = value;
            REG_DRIVE_Y_GAIN: drive_y_gain = value[5:0];
            REG_STOP_BAND_X:  stop_band_x  = value;
            REG_STOP_BAND_Y:  stop_band_y  = value;
            default: ;
        endcase
    endtask

    task automatic absorb_sample(opcode_t op, logic [BYTE_W-1:0] xb, logic [BYTE_W-1:0] yb);
        int            sx;
        int            sy;
        int            tx;
        int            ty;
        int            ax;
        int            ay;
        steer_result_t r;
        sx = accel_value(xb);
        sy = accel_value(yb);
        if (op == OP_CAL)
        begin
            cal_sum_x += sx;
            cal_sum_y += sy;
            cal_count++;
            if (cal_count == CAL_SAMPLES)
            begin
                offset_x  = cal_sum_x / CAL_SAMPLES;
                offset_y  = cal_sum_y / CAL_SAMPLES;
                cal_sum_x = 0;
                cal_sum_y = 0;
                cal_count = 0;
                n_cal++;
            end
        end
        else
        begin
            run_sum_x += sx;
            run_sum_y += sy;
            run_count++;
            if (run_count == AVG_SAMPLES)
            begin
                tx        = floor_avg(run_sum_x) - offset_x;
                ty        = floor_avg(run_sum_y) - offset_y;
                run_sum_x = 0;
                run_sum_y = 0;
                run_count = 0;
                ax        = (tx < 0) ? -tx : tx;
                ay        = (ty < 0) ? -ty : ty;
                if (!stop_latch)
                begin
                    if (direction == DIR_UPHILL)
                        held_steering = clamp_width(longint'(CENTER_W)
                                                    + longint'(steer_gain) * tx);
                    else if (direction == DIR_DOWNHILL)
                        held_steering = clamp_width(longint'(CENTER_W)
                                                    - longint'(steer_gain) * tx);
                end
                if (ax < int'(stop_band_x) && ay < int'(stop_band_y))
                    stop_latch = 1'b1;
                r.stopped = stop_latch;
                if (stop_latch)
                begin
                    r.steering_width = CENTER_W;
                    r.drive_width    = CENTER_W;
                end
                else
                begin
                    r.steering_width = held_steering;
                    r.drive_width    = clamp_width(longint'(CENTER_W)
                                                   + longint'(drive_y_gain) * ay
                                                   + longint'(drive_x_gain) * ax);
                end
                r.tilt_x = TILT_W'(tx);
                r.tilt_y = TILT_W'(ty);
                awaited_groups.push_back(r);
            end
        end
    endtask

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("%0t: %s", $time, msg);
    endtask

    task automatic compare_result();
        steer_result_t want;
        if (awaited_groups.size() == 0)
        begin
            report_mismatch($sformatf("result item with no group waiting, steering %0d drive %0d",
                                      results.steering_width, results.drive_width));
        end
        else
        begin
            want = awaited_groups.pop_front();
            n_groups++;
            if (want.stopped)
                n_stops++;
            if (results.steering_width !== want.steering_width)
                report_mismatch($sformatf("group %0d steering_width got %0d expected %0d",
                                          n_groups, results.steering_width,
                                          want.steering_width));
            if (results.drive_width !== want.drive_width)
                report_mismatch($sformatf("group %0d drive_width got %0d expected %0d",
                                          n_groups, results.drive_width, want.drive_width));
            if (results.stopped !== want.stopped)
                report_mismatch($sformatf("group %0d stopped got %0d expected %0d",
                                          n_groups, results.stopped, want.stopped));
            if (results.tilt_x !== want.tilt_x)
                report_mismatch($sformatf("group %0d tilt_x got %0d expected %0d",
                                          n_groups, results.tilt_x, want.tilt_x));
            if (results.tilt_y !== want.tilt_y)
                report_mismatch($sformatf("group %0d tilt_y got %0d expected %0d",
                                          n_groups, results.tilt_y, want.tilt_y));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                apply_write(cfg.index, cfg.data);
            if (samples.valid && samples.ready)
                absorb_sample(samples.opcode, samples.accel_x_byte, samples.accel_y_byte);
            if (results.valid && results.ready)
                compare_result();
        end
        fail_count     <= mismatches;
        pending        <= awaited_groups.size();
        groups_checked <= n_groups;
        stop_groups    <= n_stops;
        cal_blocks     <= n_cal;
    end

endmodule

/* test/tb_tilt_proportional_drive_steer.sv */
`timescale 1ns / 100ps
// Testbench top: drives samples and register writes into the tilt steering block.
module tb_tilt_proportional_drive_steer;
    import tpds_pkg::*;

    localparam int                   WATCHDOG_LIMIT = 4000;
    localparam int                   SETTLE_CYCLES  = 8;
    localparam int                   LONG_HOLD      = 200;
    localparam int                   PHASE_ITEMS    = 100;
    localparam int                   CAL_SAMPLES    = 64;
    localparam int                   AVG_SAMPLES    = 8;
    localparam logic [1:0]           DIR_SPARE      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX    = 3'd6;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   groups_checked;
    int   stop_groups;
    int   cal_blocks;
    int   samples_sent = 0;
    int   cal_sent = 0;
    int   settings_loaded = 0;
    int   quiet_cycles = 0;

    tpds_sample_if smp();
    tpds_result_if res();
    tpds_cfg_if    cfg_ch();

    tilt_proportional_drive_steer DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (smp),
        .results (res),
        .cfg     (cfg_ch)
    );

    tpds_drive_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .samples        (smp),
        .results        (res),
        .cfg            (cfg_ch),
        .fail_count     (fail_count),
        .pending        (pending),
        .groups_checked (groups_checked),
        .stop_groups    (stop_groups),
        .cal_blocks     (cal_blocks)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [BYTE_W-1:0] scatter_byte(logic [BYTE_W-1:0] base, int spread);
        int d;
        d = int'($urandom_range(0, 2 * spread)) - spread;
        return base + BYTE_W'(d);
    endfunction

    task automatic send_sample(opcode_t op, logic [BYTE_W-1:0] xb, logic [BYTE_W-1:0] yb);
        int gap;
        gap = ((samples_sent / 40) % 4 == 3) ? 0 : int'($urandom_range(0, 3));
        if (gap > 0)
        begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp.valid        <= 1'b1;
        smp.opcode       <= op;
        smp.accel_x_byte <= xb;
        smp.accel_y_byte <= yb;
        @(posedge clk);
        while (!smp.ready)
            @(posedge clk);
        samples_sent++;
        if (op == OP_CAL)
            cal_sent++;
    endtask

    task automatic send_group(logic [BYTE_W-1:0] base_x, logic [BYTE_W-1:0] base_y,
                              int spread, bit with_stray);
        int stray_at;
        stray_at = with_stray ? int'($urandom_range(0, AVG_SAMPLES - 1)) : -1;
        for (int i = 0; i < AVG_SAMPLES; i++)
        begin
            if (i == stray_at)
                send_sample(OP_CAL, BYTE_W'($urandom), BYTE_W'($urandom));
            send_sample(OP_RUN, scatter_byte(base_x, spread), scatter_byte(base_y, spread));
        end
    endtask

    task automatic send_cal_burst(int count, logic [BYTE_W-1:0] base_x,
                                  logic [BYTE_W-1:0] base_y, int spread);
        for (int i = 0; i < count; i++)
            send_sample(OP_CAL, scatter_byte(base_x, spread), scatter_byte(base_y, spread));
    endtask

    task automatic random_phase(int quota);
        int              start;
        int              pick;
        int              spread;
        logic [BYTE_W-1:0] bx;
        logic [BYTE_W-1:0] by_base;
        start = samples_sent;
        while (samples_sent - start < quota)
        begin
            pick    = $urandom_range(0, 99);
            bx      = BYTE_W'($urandom);
            by_base = BYTE_W'($urandom);
            case ($urandom_range(0, 3))
                0:       spread = 0;
                1:       spread = 3;
                2:       spread = 40;
                default: spread = 127;
            endcase
            if (pick < 3)
                send_cal_burst(CAL_SAMPLES, bx, by_base, $urandom_range(0, 4));
            else if (pick < 9)
                send_cal_burst($urandom_range(1, 20), bx, by_base, 127);
            else
                send_group(bx, by_base, spread, pick >= 90);
        end
    endtask

    task automatic settle();
        smp.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic load_settings(logic [1:0] dir, logic [7:0] sg, logic [7:0] dxg,
                                 logic [7:0] dyg, logic [7:0] band_x, logic [7:0] band_y);
        logic [5:0] upper;
        upper = 6'($urandom);
        write_reg(REG_DIRECTION, {upper, dir});
        write_reg(REG_STEER_GAIN, sg);
        write_reg(REG_DRIVE_X_GAIN, dxg);
        write_reg(REG_DRIVE_Y_GAIN, dyg);
        write_reg(REG_STOP_BAND_X, band_x);
        write_reg(REG_STOP_BAND_Y, band_y);
        write_reg(SPARE_INDEX, 8'($urandom));
        write_reg(SPARE_INDEX + 1'b1, 8'($urandom));
        cfg_ch.valid <= 1'b0;
        settings_loaded++;
    endtask

    initial
    begin
        int                zero_x;
        logic [BYTE_W-1:0] level;
        rst_n            <= 1'b0;
        smp.valid        <= 1'b0;
        smp.opcode       <= OP_CAL;
        smp.accel_x_byte <= '0;
        smp.accel_y_byte <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_DIRECTION;
        cfg_ch.data      <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_group(8'h7F, 8'h80, 0, 1'b0);
        send_cal_burst(3, 8'h80, 8'h80, 0);
        for (int i = 0; i < AVG_SAMPLES; i++)
        begin
            if (i == 3 || i == 6)
                send_sample(OP_CAL, 8'h7F, 8'h00);
            send_sample(OP_RUN, i[0] ? 8'h7F : 8'h80, 8'h7F);
        end
        settle();

        load_settings(DIR_UPHILL, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF);
        random_phase(PHASE_ITEMS);
        settle();
        load_settings(DIR_DOWNHILL, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00);
        random_phase(PHASE_ITEMS);
        settle();
        load_settings(DIR_NONE, 8'($urandom), 8'($urandom), 8'($urandom), 8'h00,
                      8'($urandom));
        random_phase(PHASE_ITEMS);
        settle();
        load_settings(DIR_SPARE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'h00);
        random_phase(PHASE_ITEMS);
        settle();
        repeat (3)
        begin
            zero_x = $urandom_range(0, 1);
            load_settings(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          zero_x ? 8'h00 : 8'($urandom), zero_x ? 8'($urandom) : 8'h00);
            random_phase(PHASE_ITEMS);
            settle();
        end

        // The stop latch holds until reset, so the level case is driven last.
        load_settings(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'hFF, 8'hFF);
        level = BYTE_W'($urandom);
        while (cal_sent % CAL_SAMPLES != 0)
            send_sample(OP_CAL, level, level);
        send_cal_burst(CAL_SAMPLES, level, level, 0);
        send_group(level ^ 8'h80, level ^ 8'h80, 0, 1'b0);
        send_group(level, level, 0, 1'b0);
        random_phase(PHASE_ITEMS / 2);
        settle();

        $display("Run sent %0d sample items over %0d register settings, closing %0d offset blocks.",
                 samples_sent, settings_loaded, cal_blocks);
        $display("Checked %0d result items, %0d of them with the stop latch set.",
                 groups_checked, stop_groups);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int hold;
        int taken;
        hold      = 0;
        taken     = 0;
        res.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        res.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (res.ready && res.valid)
            begin
                taken++;
                if (taken == 15 || taken == 45)
                    hold = LONG_HOLD;
                else if ((taken / 10) % 4 == 3)
                    hold = 0;
                else
                    hold = $urandom_range(0, 3);
                if (hold > 0)
                    res.ready <= 1'b0;
            end
            else if (!res.ready)
            begin
                hold--;
                if (hold == 0)
                    res.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (smp.valid && smp.ready) || (res.valid && res.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
